// File: design/lrukv_pkg.sv
`default_nettype none

package lrukv_pkg;

  localparam int unsigned DEF_ENTRIES = 16;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0]  store_value;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [DATA_W-1:0]  read_value;
  } out_t;

  typedef struct packed {
    logic en;
    logic wr_key;
    logic wr_val;
    logic set_valid;
  } cell_op_t;

endpackage

`default_nettype wire

// File: design/lrukv_cell.sv
`default_nettype none

module lrukv_cell
  import lrukv_pkg::*;
#(
  parameter int unsigned IW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_op_t          op,
  input  wire logic              sel,
  input  wire logic [IW-1:0]     ref_age,
  input  wire logic [IW-1:0]     lru_age,
  input  wire logic [DATA_W-1:0] key,
  input  wire logic [DATA_W-1:0] value,
  output logic                   valid,
  output logic                   match,
  output logic                   lru,
  output logic [IW-1:0]          age,
  output logic [DATA_W-1:0]      stored
);

  logic              valid_r, valid_nxt;
  logic [IW-1:0]     age_r, age_nxt;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] val_r;

  assign valid  = valid_r;
  assign age    = age_r;
  assign stored = val_r;
  assign match  = valid_r && (key_r == key);
  assign lru    = valid_r && (age_r == lru_age);

  always_comb begin
    valid_nxt = valid_r;
    age_nxt   = age_r;
    if (op.en) begin
      if (sel) begin
        age_nxt = '0;
        if (op.set_valid) begin
          valid_nxt = 1'b1;
        end
      end else if (valid_r && (age_r < ref_age)) begin
        age_nxt = age_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op.en && sel && op.wr_key) begin
      key_r <= key;
    end
    if (op.en && sel && op.wr_val) begin
      val_r <= value;
    end
  end

endmodule

`default_nettype wire

// File: design/lrukv_pick.sv
`default_nettype none

module lrukv_pick #(
  parameter int unsigned N  = 16,
  parameter int unsigned IW = 4
) (
  input  wire logic [N-1:0]  req,
  output logic      [IW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/lru_key_value_cache_core.sv
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// A word is taken on any cycle with start high; busy stays low, so one get
// or put enters every clock. Each word is registered, then matched against
// all entries in parallel, and its result is registered and shown on out_word
// with out_valid high for exactly one cycle. The receiver
// cannot stall, so it must take every result in the cycle it appears. The
// entry limit may be written through the cfg port only while no word is in
// flight; it is always ready.

module lru_key_value_cache_core
  import lrukv_pkg::*;
#(
  parameter int unsigned ENTRIES = DEF_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_t                in_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data,
  output logic                    out_valid,
  output out_t                    out_word
);

  localparam int unsigned IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [LIMIT_W-1:0] limit_r;
  logic               req_vld_r;
  in_t                req_r;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic               out_vld_r;
  out_t               out_r, out_nxt;

  logic [ENTRIES-1:0] vld_v, match_v, lru_v;
  logic [IW-1:0]      age_a [ENTRIES];
  logic [DATA_W-1:0]  val_a [ENTRIES];
  logic [IW-1:0]      hit_idx, free_idx, lru_idx, tgt;
  logic [IW-1:0]      ref_age, lru_age;
  logic [LIMIT_W-1:0] lim_min;
  logic               hit, full;
  cell_op_t           op;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_word  = out_r;

  lrukv_pick #(.N(ENTRIES), .IW(IW)) u_pick_hit (.req(match_v), .idx(hit_idx));
  lrukv_pick #(.N(ENTRIES), .IW(IW)) u_pick_free (.req(~vld_v), .idx(free_idx));
  lrukv_pick #(.N(ENTRIES), .IW(IW)) u_pick_lru (.req(lru_v), .idx(lru_idx));

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrukv_cell #(.IW(IW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .sel     (tgt == IW'(g)),
      .ref_age (ref_age),
      .lru_age (lru_age),
      .key     (req_r.lookup_key),
      .value   (req_r.store_value),
      .valid   (vld_v[g]),
      .match   (match_v[g]),
      .lru     (lru_v[g]),
      .age     (age_a[g]),
      .stored  (val_a[g])
    );
  end

  // Ages form a permutation of 0 to fill-1, so the oldest entry has age fill-1.
  assign lru_age = IW'(fill_r - CW'(1));
  assign hit     = |match_v;
  assign lim_min = (limit_r == '0) ? LIMIT_W'(1) : limit_r;
  assign full    = (CMP_W'(fill_r) >= CMP_W'(lim_min)) ||
                   (CMP_W'(fill_r) >= CMP_W'(ENTRIES));

  always_comb begin
    op                 = '0;
    tgt                = hit_idx;
    ref_age            = age_a[hit_idx];
    fill_nxt           = fill_r;
    out_nxt.hit        = hit;
    out_nxt.read_value = '0;
    if (req_vld_r) begin
      op.en = 1'b1;
      if (req_r.mode == MODE_GET) begin
        op.en              = hit;
        out_nxt.read_value = hit ? val_a[hit_idx] : MISS_VALUE;
      end else if (hit) begin
        op.wr_val = 1'b1;
      end else if (!full) begin
        tgt          = free_idx;
        ref_age      = IW'(fill_r);
        op.wr_key    = 1'b1;
        op.wr_val    = 1'b1;
        op.set_valid = 1'b1;
        fill_nxt     = fill_r + CW'(1);
      end else begin
        tgt       = lru_idx;
        ref_age   = lru_age;
        op.wr_key = 1'b1;
        op.wr_val = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RST;
      req_vld_r <= 1'b0;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      req_vld_r <= start && !busy;
      fill_r    <= fill_nxt;
      out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_word;
    end
    if (req_vld_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire
